// ===== hdl/gsr_pkg.sv =====
`timescale 1ns / 1ps
package gsr_pkg;

    // Instruction FIFO geometry.
    localparam int FIFO_DEPTH  = 128;
    localparam int INSTR_BYTES = 20;
    localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_DEPTH   = FIFO_DEPTH * INSTR_BYTES;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int IDX_W       = $clog2(INSTR_BYTES);
    localparam int TBL_LEN     = 7;

    // Protocol state codes (command codes double as state codes).
    localparam logic [7:0] ST_HEADER   = 8'h00;
    localparam logic [7:0] ST_PRESSURE = 8'h40;
    localparam logic [7:0] ST_RSPMASK  = 8'h41;
    localparam logic [7:0] ST_POLL     = 8'h42;
    localparam logic [7:0] ST_CONFIG   = 8'h43;
    localparam logic [7:0] ST_MODE     = 8'h44;
    localparam logic [7:0] ST_STATUS   = 8'h45;
    localparam logic [7:0] ST_CONST0   = 8'h46;
    localparam logic [7:0] ST_CONST1   = 8'h47;
    localparam logic [7:0] ST_CONST2   = 8'h4C;
    localparam logic [7:0] ST_MOTOR    = 8'h4D;
    localparam logic [7:0] ST_BYTESET  = 8'h4F;
    localparam logic [7:0] ST_BAD      = 8'hFF;

    // Mode codes and fixed bytes.
    localparam logic [7:0] MODE_DIGITAL   = 8'h41;
    localparam logic [7:0] MODE_ANALOG    = 8'h73;
    localparam logic [7:0] MODE_PRESSURES = 8'h79;
    localparam logic [7:0] MODE_CONFIG    = 8'hF3;
    localparam logic [7:0] HDR_START      = 8'h01;
    localparam logic [7:0] HDR_ACK        = 8'h5A;
    localparam logic [7:0] BYTE_FILL      = 8'hFF;

    // One queued request.
    typedef struct packed {
        logic       is_dep;
        logic [7:0] data;
    } t_item;

    // Queue status toward the engine.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q;

    function automatic logic known_cmd(input logic [7:0] c);
        return (c >= ST_PRESSURE && c <= ST_CONST1) || c == ST_CONST2 ||
               c == ST_MOTOR || c == ST_BYTESET;
    endfunction

    function automatic logic [7:0] poll_default(input logic [4:0] i);
        case (i)
            5'd0, 5'd1, 5'd18: return 8'hFF;
            5'd2, 5'd3, 5'd4, 5'd5: return 8'h7F;
            5'd19: return 8'h03;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] pressure_tbl(input logic [2:0] i);
        case (i)
            3'd2: return 8'h02;
            3'd5: return 8'h5A;
            3'd6: return 8'hFF;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] const1_tbl(input logic [2:0] i);
        case (i)
            3'd2: return 8'h02;
            3'd6: return 8'hFF;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] byteset_tbl(input logic [2:0] i);
        case (i)
            3'd5: return 8'h5A;
            3'd6: return 8'hFF;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] status_tbl(input logic [2:0] i, input logic flag);
        case (i)
            3'd0: return 8'h03;
            3'd1: return 8'h02;
            3'd2: return {7'd0, flag};
            3'd3: return 8'h02;
            3'd4: return 8'h01;
            3'd6: return 8'hFF;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [15:0] const0_tbl(input logic [2:0] i);
        case (i)
            3'd3: return 16'h0002;
            3'd5: return 16'h140A;
            3'd6: return 16'h00FF;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [15:0] const2_tbl(input logic [2:0] i);
        case (i)
            3'd3: return 16'h0604;
            3'd6: return 16'h00FF;
            default: return 16'h0000;
        endcase
    endfunction

    // Selects the low or high byte of a constant entry, or echoes the input.
    function automatic logic [7:0] const_pick(input logic [15:0] v, input logic [7:0] sel,
                                              input logic [7:0] echo);
        if (sel == 8'd0) return v[7:0];
        if (sel == 8'd1) return v[15:8];
        return echo;
    endfunction

endpackage

// ===== hdl/gsr_in_if.sv =====
`timescale 1ns / 1ps
interface gsr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// ===== hdl/gsr_out_if.sv =====
`timescale 1ns / 1ps
interface gsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       ack_pulse;
    logic       packet_done;
    logic       deposit_ok;

    modport source (output valid, output reply_byte, output ack_pulse, output packet_done,
                    output deposit_ok, input ready);
    modport sink   (input valid, input reply_byte, input ack_pulse, input packet_done,
                    input deposit_ok, output ready);
endinterface

// ===== hdl/gsr_front.sv =====
`timescale 1ns / 1ps
module gsr_front import gsr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gsr_in_if.sink    i_in,
    output t_q        o_q,
    input  logic      i_pop
);

    t_item      r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    // Two-entry request queue; each request is tagged as deposit or console byte.
    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_cnt != 2'd0);
    assign o_q.valid  = (r_cnt != 2'd0);
    assign o_q.item   = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_buf[r_wr] <= '{is_dep: i_in.func, data: i_in.data_byte};
                r_wr        <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hdl/gsr_engine.sv =====
`timescale 1ns / 1ps
module gsr_engine import gsr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q        i_q,
    output logic      o_pop,
    gsr_out_if.source o_out
);

    typedef enum logic {S_RUN, S_COPY} t_eng;

    t_eng             r_eng, n_eng;
    logic [7:0]       r_state, n_state;
    logic [4:0]       r_idx, n_idx;
    logic [4:0]       r_len, n_len;
    logic [7:0]       r_dev_mode, n_dev_mode;
    logic [7:0]       r_hdr_mode, n_hdr_mode;
    logic [7:0]       r_csel, n_csel;
    logic             r_aflag, n_aflag;
    logic [7:0]       r_motor [TBL_LEN];
    logic [7:0]       n_motor [TBL_LEN];
    logic [7:0]       r_mask [TBL_LEN];
    logic [7:0]       n_mask [TBL_LEN];
    logic [7:0]       r_poll [INSTR_BYTES];
    logic [7:0]       n_poll [INSTR_BYTES];
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_dep_idx, n_dep_idx;
    logic             r_dep_drop, n_dep_drop;
    logic [4:0]       r_cp_k, n_cp_k;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_reply, n_reply;
    logic             r_ack, n_ack;
    logic             r_done, n_done;
    logic             r_ok, n_ok;

    logic [7:0]       r_mem [MEM_DEPTH];
    logic [7:0]       r_rd_data;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic             mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic             fire;
    logic [7:0]       d;
    logic             drop;
    logic             abort;
    logic             cmd_sel;
    logic [5:0]       idx_nx;
    logic [7:0]       rep;
    logic [2:0]       ti;
    logic             in_tbl;
    logic [2:0]       wi;

    assign o_out.valid       = r_out_valid;
    assign o_out.reply_byte  = r_reply;
    assign o_out.ack_pulse   = r_ack;
    assign o_out.packet_done = r_done;
    assign o_out.deposit_ok  = r_ok;

    // A request is taken when the result register is free or being drained.
    assign fire  = (r_eng == S_RUN) && i_q.valid && (!r_out_valid || o_out.ready);
    assign o_pop = fire;
    assign d     = i_q.item.data;
    assign ti    = r_idx[2:0];
    assign in_tbl = (r_idx < 5'(TBL_LEN));
    assign wi    = 3'(r_idx - 5'd1);
    assign idx_nx = {1'b0, r_idx} + 6'd1;

    // Instruction store: deposit write port, refill read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= d;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign drop      = (r_dep_idx == '0) ? (r_count >= CNT_W'(FIFO_DEPTH)) : r_dep_drop;
    assign mem_we    = fire && i_q.item.is_dep && !drop;
    assign mem_waddr = ADDR_W'(r_tail) * ADDR_W'(INSTR_BYTES) + ADDR_W'(r_dep_idx);
    assign mem_re    = (r_eng == S_COPY) && (r_cp_k < 5'(INSTR_BYTES));
    assign mem_raddr = ADDR_W'(r_head) * ADDR_W'(INSTR_BYTES) + ADDR_W'(r_cp_k);

    // Next-state logic for protocol, tables, FIFO pointers and refill.
    always_comb begin
        n_eng = r_eng; n_state = r_state; n_idx = r_idx; n_len = r_len;
        n_dev_mode = r_dev_mode; n_hdr_mode = r_hdr_mode; n_csel = r_csel;
        n_aflag = r_aflag; n_motor = r_motor; n_mask = r_mask; n_poll = r_poll;
        n_head = r_head; n_tail = r_tail; n_count = r_count;
        n_dep_idx = r_dep_idx; n_dep_drop = r_dep_drop; n_cp_k = r_cp_k;
        n_out_valid = r_out_valid && !o_out.ready;
        n_reply = r_reply; n_ack = r_ack; n_done = r_done; n_ok = r_ok;
        abort = 1'b0; cmd_sel = 1'b0; rep = BYTE_FILL;

        if (r_eng == S_COPY) begin
            // One byte of the next instruction lands in the poll packet per cycle.
            if (r_cp_k != 5'd0) begin
                n_poll[IDX_W'(r_cp_k - 5'd1)] = r_rd_data;
            end
            n_cp_k = r_cp_k + 5'd1;
            if (r_cp_k == 5'(INSTR_BYTES)) begin
                n_eng   = S_RUN;
                n_head  = (r_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_count = r_count - 1'b1;
            end
        end else if (fire && i_q.item.is_dep) begin
            // Host deposit of one instruction byte.
            n_dep_drop = drop;
            n_out_valid = 1'b1;
            n_reply = 8'h00; n_ack = 1'b0; n_done = 1'b0; n_ok = !drop;
            if (r_dep_idx == IDX_W'(INSTR_BYTES - 1)) begin
                n_dep_idx = '0;
                if (!drop) begin
                    n_tail  = (r_tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end else begin
                n_dep_idx = r_dep_idx + 1'b1;
            end
        end else if (fire) begin
            n_out_valid = 1'b1;
            n_ok = 1'b0;
            if (r_state == ST_HEADER && r_idx != 5'd0) begin
                // Second header byte picks the command.
                cmd_sel = 1'b1;
                if (d == ST_POLL) begin
                    n_hdr_mode = r_dev_mode;
                    n_state    = ST_POLL;
                    n_len      = {r_dev_mode[3:0], 1'b0};
                end else if (d == ST_CONFIG) begin
                    n_state = ST_CONFIG;
                    n_len   = {r_hdr_mode[3:0], 1'b0};
                end else if (r_hdr_mode == MODE_CONFIG) begin
                    n_state = known_cmd(d) ? d : ST_BAD;
                    n_len   = 5'd6;
                end else begin
                    abort = 1'b1;
                end
            end else begin
                case (r_state)
                    ST_HEADER: begin
                        if (d != HDR_START) abort = 1'b1;
                        rep = r_hdr_mode;
                    end
                    ST_PRESSURE: rep = in_tbl ? pressure_tbl(ti) : BYTE_FILL;
                    ST_RSPMASK:  rep = in_tbl ? r_mask[ti] : BYTE_FILL;
                    ST_POLL: begin
                        rep = (r_idx < 5'(INSTR_BYTES)) ? r_poll[IDX_W'(r_idx)] : BYTE_FILL;
                        if (r_idx == r_len) begin
                            if (r_poll[INSTR_BYTES-1] > 8'd1) begin
                                n_poll[INSTR_BYTES-1] = r_poll[INSTR_BYTES-1] - 8'd1;
                            end else if (r_count != '0) begin
                                n_eng  = S_COPY;
                                n_cp_k = 5'd0;
                            end
                        end
                    end
                    ST_CONFIG: begin
                        rep = (r_idx < 5'(INSTR_BYTES)) ? r_poll[IDX_W'(r_idx)] : BYTE_FILL;
                        if (r_idx == 5'd1) begin
                            if (d == 8'h01) n_hdr_mode = MODE_CONFIG;
                            else if (d == 8'h00) n_hdr_mode = r_dev_mode;
                        end
                    end
                    ST_MODE: begin
                        rep = 8'h00;
                        if (r_idx == 5'd1) begin
                            if (d == 8'h00) begin
                                n_dev_mode = MODE_DIGITAL; n_aflag = 1'b0;
                            end else if (d == 8'h01) begin
                                n_dev_mode = MODE_ANALOG; n_aflag = 1'b1;
                            end
                        end
                    end
                    ST_STATUS: rep = in_tbl ? status_tbl(ti, r_aflag) : BYTE_FILL;
                    ST_CONST0: begin
                        rep = in_tbl ? const_pick(const0_tbl(ti), r_csel, d) : BYTE_FILL;
                        if (r_idx == 5'd1) n_csel = d;
                    end
                    ST_CONST1: rep = in_tbl ? const1_tbl(ti) : BYTE_FILL;
                    ST_CONST2: begin
                        rep = in_tbl ? const_pick(const2_tbl(ti), r_csel, d) : BYTE_FILL;
                        if (r_idx == 5'd1) n_csel = d;
                    end
                    ST_MOTOR: begin
                        rep = in_tbl ? r_motor[ti] : BYTE_FILL;
                        if (r_idx != 5'd0 && r_idx <= 5'(TBL_LEN)) n_motor[wi] = d;
                    end
                    ST_BYTESET: begin
                        rep = in_tbl ? byteset_tbl(ti) : BYTE_FILL;
                        if (r_idx != 5'd0 && r_idx <= 5'(TBL_LEN)) n_mask[wi] = d;
                        if (r_idx == 5'd1) n_dev_mode = MODE_PRESSURES;
                    end
                    default: abort = 1'b1;
                endcase
            end

            // Result of the console byte.
            if (abort) begin
                n_state = ST_HEADER; n_idx = 5'd0; n_len = 5'd2;
                n_reply = BYTE_FILL; n_ack = 1'b0; n_done = 1'b1;
            end else if (cmd_sel) begin
                n_idx = 5'd0;
                n_reply = HDR_ACK; n_ack = 1'b1; n_done = 1'b0;
            end else if (idx_nx <= {1'b0, r_len}) begin
                n_idx = idx_nx[4:0];
                n_reply = rep; n_ack = 1'b1; n_done = 1'b0;
            end else begin
                n_state = ST_HEADER; n_idx = 5'd0; n_len = 5'd2;
                n_reply = rep; n_ack = 1'b0; n_done = 1'b1;
            end
        end
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng <= S_RUN; r_state <= ST_HEADER; r_idx <= 5'd0; r_len <= 5'd2;
            r_dev_mode <= MODE_DIGITAL; r_hdr_mode <= MODE_DIGITAL; r_csel <= 8'd0;
            r_aflag <= 1'b0;
            for (int k = 0; k < TBL_LEN; k++) begin
                r_motor[k] <= 8'hFF;
                r_mask[k]  <= (k == TBL_LEN - 1) ? 8'hFF : 8'h00;
            end
            for (int k = 0; k < INSTR_BYTES; k++) begin
                r_poll[k] <= poll_default(5'(k));
            end
            r_head <= '0; r_tail <= '0; r_count <= '0;
            r_dep_idx <= '0; r_dep_drop <= 1'b0; r_cp_k <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_eng <= n_eng; r_state <= n_state; r_idx <= n_idx; r_len <= n_len;
            r_dev_mode <= n_dev_mode; r_hdr_mode <= n_hdr_mode; r_csel <= n_csel;
            r_aflag <= n_aflag; r_motor <= n_motor; r_mask <= n_mask; r_poll <= n_poll;
            r_head <= n_head; r_tail <= n_tail; r_count <= n_count;
            r_dep_idx <= n_dep_idx; r_dep_drop <= n_dep_drop; r_cp_k <= n_cp_k;
            r_out_valid <= n_out_valid;
        end
        r_reply <= n_reply; r_ack <= n_ack; r_done <= n_done; r_ok <= n_ok;
    end

endmodule

// ===== hdl/gamepad_spi_responder_top.sv =====
`timescale 1ns / 1ps
// Controller-side responder for a game-controller SPI link.
// Input channel i_in carries one request per exchanged console byte
// (func = 0) or per host instruction byte deposited (func = 1).
// Output channel o_out returns exactly one result per request: the reply
// byte for the next exchange, the acknowledge and end-of-packet flags, and
// for deposits whether the byte was accepted into the instruction FIFO.
// A request passes the input queue, then the result register; one request
// per cycle is sustained while the receiver keeps up and no copy runs.
// When a poll packet's repeat count runs out and an instruction is queued,
// the engine copies the 20 instruction bytes from the instruction memory,
// one byte per cycle over its single read port, and holds off the next
// request until the copy is complete.
// Reset puts the protocol in the header state, restores the default poll
// packet and empties the FIFO; the instruction memory is not cleared.
// If the receiver stalls, the result is held and the two-entry input
// queue fills before i_in.ready drops.
module gamepad_spi_responder_top import gsr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gsr_in_if.sink    i_in,
    gsr_out_if.source o_out
);

    t_q   q;
    logic pop;

    gsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_q     (q),
        .i_pop   (pop)
    );

    gsr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q),
        .o_pop   (pop),
        .o_out   (o_out)
    );

`ifndef SYNTH
    // An accepted deposit result never carries console fields.
    a_dep_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.deposit_ok) |-> (o_out.reply_byte == 8'h00 &&
        !o_out.ack_pulse && !o_out.packet_done))
        else $error("deposit result carries console fields");

    // A byte that ends the packet is never acknowledged.
    a_done_noack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.ack_pulse && o_out.packet_done))
        else $error("acknowledge on a packet-ending byte");

    // The engine only takes requests that are queued.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q.valid)
        else $error("pop from empty queue");
`endif

endmodule
